[rtl/btxq_pkg.sv]
`timescale 1ns / 1ps
// shared types and codes of the binary trie xor query unit
package btxq_pkg;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_DEL = 2'd1,
    KIND_MAX = 2'd2,
    KIND_MIN = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_EMPTY  = 2'd1,
    STAT_ABSENT = 2'd2,
    STAT_FULL   = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_STEP,
    ST_ADD_LOAD,
    ST_DCHK_STEP,
    ST_DCHK_LOAD,
    ST_DUPD_STEP,
    ST_DUPD_LOAD,
    ST_QRY_STEP,
    ST_QRY_LOAD,
    ST_RESP
  } state_e;

endpackage

[rtl/btxq_if.sv]
`timescale 1ns / 1ps
// request and result channel interfaces of the binary trie xor query unit
interface btxq_req_if #(
  parameter int KEY_BITS = 30
);
  logic                valid;
  logic                ready;
  logic [1:0]          kind;
  logic [KEY_BITS-1:0] key;

  modport source (output valid, kind, key, input ready);
  modport sink   (input valid, kind, key, output ready);
endinterface

interface btxq_rsp_if #(
  parameter int KEY_BITS = 30
);
  logic                valid;
  logic                ready;
  logic [KEY_BITS-1:0] answer;
  logic [1:0]          status;

  modport source (output valid, answer, status, input ready);
  modport sink   (input valid, answer, status, output ready);
endinterface

[rtl/binary_trie_xor_query_unit.sv]
`timescale 1ns / 1ps
// top level of the binary trie xor query unit
//
// Keeps a multiset of keys in a bitwise trie and answers max / min xor queries.
// req_i takes one item (kind, key) when valid and ready are both high; ready
// is high only while no item is being worked on. rsp_o gives one result item
// (answer, status) for every request item, held in an output register until
// taken, so a new request is taken while a result still waits.
// The trie walks one level per step state; a level that reads a node takes a
// step state and a load state. add walks once and allocates missing nodes
// without a read, delete runs a check walk then an update walk, a query walks
// once and reads both children of a node, and a rejected add or an empty
// query goes straight to the result state.
// Reset clears the root node, sets the allocation pointer to one and empties
// the output register; other nodes are written when allocated, so no clearing
// pass is needed. When the receiver stalls, the finished result waits in the
// output register and the next one waits in the block until the slot frees.
module binary_trie_xor_query_unit
  import btxq_pkg::*;
#(
  parameter int KEY_BITS   = 30,
  parameter int NODE_COUNT = 4096,
  parameter int COUNT_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  btxq_req_if.sink       req_i,
  btxq_rsp_if.source     rsp_o
);

  localparam int IDX_BITS = $clog2(NODE_COUNT);
  localparam int NF_BITS  = IDX_BITS + 1;
  localparam int ENTRY_W  = 2 * IDX_BITS + COUNT_BITS;
  localparam int REM_BITS = $clog2(KEY_BITS + 1);

  state_e state_q, state_d;

  logic [IDX_BITS-1:0]   root_l0_q, root_l0_d, root_l1_q, root_l1_d;
  logic [COUNT_BITS-1:0] root_cnt_q, root_cnt_d;
  logic [NF_BITS-1:0]    next_free_q, next_free_d;

  logic [IDX_BITS-1:0]   cur_l0_q, cur_l0_d, cur_l1_q, cur_l1_d, cur_idx_q, cur_idx_d;
  logic [COUNT_BITS-1:0] cur_cnt_q, cur_cnt_d;
  logic [KEY_BITS-1:0]   key_q, key_d, key_sh_q, key_sh_d, ans_q, ans_d;
  logic [REM_BITS-1:0]   rem_q, rem_d;
  logic                  max_q, max_d;
  status_e               res_status_q, res_status_d;
  logic [KEY_BITS-1:0]   res_ans_q, res_ans_d;

  logic                  out_valid_q, out_valid_d;
  logic [KEY_BITS-1:0]   out_ans_q, out_ans_d;
  status_e               out_status_q, out_status_d;

  logic [ENTRY_W-1:0]    node_mem [NODE_COUNT];
  logic [ENTRY_W-1:0]    rd_a_q, rd_b_q;
  logic [IDX_BITS-1:0]   raddr_a, raddr_b, waddr;
  logic [ENTRY_W-1:0]    wdata;
  logic                  mem_we;

  logic                  accept, bit_w, full_w, slot_free;
  logic [IDX_BITS-1:0]   child, nf_idx, new_l0, new_l1;
  logic [IDX_BITS-1:0]   rd_a_l0, rd_a_l1, rd_b_l0, rd_b_l1;
  logic [COUNT_BITS-1:0] rd_a_cnt, rd_b_cnt;
  logic                  pref, live, take;
  logic [IDX_BITS-1:0]   pref_link, take_link;
  logic [COUNT_BITS-1:0] pref_cnt;
  kind_e                 kind_w;

  assign req_i.ready  = (state_q == ST_IDLE);
  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.answer = out_ans_q;
  assign rsp_o.status = out_status_q;

  assign accept    = req_i.valid && req_i.ready;
  assign kind_w    = kind_e'(req_i.kind);
  assign slot_free = !out_valid_q || rsp_o.ready;
  assign full_w    = ((NF_BITS'(NODE_COUNT) - next_free_q) < NF_BITS'(KEY_BITS))
                     || (root_cnt_q == '1);

  assign bit_w  = key_sh_q[KEY_BITS-1];
  assign child  = bit_w ? cur_l1_q : cur_l0_q;
  assign nf_idx = next_free_q[IDX_BITS-1:0];
  assign new_l0 = (!bit_w && child == '0 && rem_q != '0) ? nf_idx : cur_l0_q;
  assign new_l1 = (bit_w && child == '0 && rem_q != '0) ? nf_idx : cur_l1_q;

  assign rd_a_l1  = rd_a_q[ENTRY_W-1 -: IDX_BITS];
  assign rd_a_l0  = rd_a_q[COUNT_BITS +: IDX_BITS];
  assign rd_a_cnt = rd_a_q[COUNT_BITS-1:0];
  assign rd_b_l1  = rd_b_q[ENTRY_W-1 -: IDX_BITS];
  assign rd_b_l0  = rd_b_q[COUNT_BITS +: IDX_BITS];
  assign rd_b_cnt = rd_b_q[COUNT_BITS-1:0];

  // port a holds the zero child, port b the one child during a query level
  assign pref      = max_q ? !bit_w : bit_w;
  assign pref_link = pref ? cur_l1_q : cur_l0_q;
  assign pref_cnt  = pref ? rd_b_cnt : rd_a_cnt;
  assign live      = (pref_link != '0) && (pref_cnt != '0);
  assign take      = live ? pref : !pref;
  assign take_link = take ? cur_l1_q : cur_l0_q;

  assign raddr_a = (state_q == ST_QRY_STEP) ? cur_l0_q : child;
  assign raddr_b = cur_l1_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      node_mem[waddr] <= wdata;
    end
    rd_a_q <= node_mem[raddr_a];
    rd_b_q <= node_mem[raddr_b];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (kind_w)
            KIND_ADD: state_d = full_w ? ST_RESP : ST_ADD_STEP;
            KIND_DEL: state_d = ST_DCHK_STEP;
            KIND_MAX, KIND_MIN: state_d = (root_cnt_q == '0) ? ST_RESP : ST_QRY_STEP;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_ADD_STEP: begin
        if (rem_q == '0) state_d = ST_RESP;
        else if (child == '0) state_d = ST_ADD_STEP;
        else state_d = ST_ADD_LOAD;
      end
      ST_ADD_LOAD: state_d = ST_ADD_STEP;
      ST_DCHK_STEP: begin
        if (rem_q == '0) state_d = (cur_cnt_q == '0) ? ST_RESP : ST_DUPD_STEP;
        else state_d = (child == '0) ? ST_RESP : ST_DCHK_LOAD;
      end
      ST_DCHK_LOAD: state_d = ST_DCHK_STEP;
      ST_DUPD_STEP: state_d = (rem_q == '0) ? ST_RESP : ST_DUPD_LOAD;
      ST_DUPD_LOAD: state_d = ST_DUPD_STEP;
      ST_QRY_STEP:  state_d = (rem_q == '0) ? ST_RESP : ST_QRY_LOAD;
      ST_QRY_LOAD:  state_d = ST_QRY_STEP;
      ST_RESP:      state_d = slot_free ? ST_IDLE : ST_RESP;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    root_l0_d    = root_l0_q;
    root_l1_d    = root_l1_q;
    root_cnt_d   = root_cnt_q;
    next_free_d  = next_free_q;
    cur_l0_d     = cur_l0_q;
    cur_l1_d     = cur_l1_q;
    cur_cnt_d    = cur_cnt_q;
    cur_idx_d    = cur_idx_q;
    key_d        = key_q;
    key_sh_d     = key_sh_q;
    ans_d        = ans_q;
    rem_d        = rem_q;
    max_d        = max_q;
    res_status_d = res_status_q;
    res_ans_d    = res_ans_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_ans_d    = out_ans_q;
    out_status_d = out_status_q;
    mem_we       = 1'b0;
    waddr        = cur_idx_q;
    wdata        = {new_l1, new_l0, cur_cnt_q};

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          key_d        = req_i.key;
          key_sh_d     = req_i.key;
          ans_d        = '0;
          rem_d        = REM_BITS'(KEY_BITS);
          max_d        = (kind_w == KIND_MAX);
          cur_l0_d     = root_l0_q;
          cur_l1_d     = root_l1_q;
          cur_cnt_d    = root_cnt_q;
          cur_idx_d    = '0;
          res_ans_d    = '0;
          res_status_d = STAT_OK;
          unique case (kind_w)
            KIND_ADD: begin
              if (full_w) begin
                res_status_d = STAT_FULL;
              end else begin
                root_cnt_d = root_cnt_q + COUNT_BITS'(1);
                cur_cnt_d  = root_cnt_q + COUNT_BITS'(1);
              end
            end
            KIND_DEL: ;
            KIND_MAX, KIND_MIN: begin
              if (root_cnt_q == '0) res_status_d = STAT_EMPTY;
            end
            default: ;
          endcase
        end
      end
      ST_ADD_STEP: begin
        // write back the current node, with a fresh link if one is allocated
        if (cur_idx_q == '0) begin
          root_l0_d  = new_l0;
          root_l1_d  = new_l1;
          root_cnt_d = cur_cnt_q;
        end else begin
          mem_we = 1'b1;
        end
        if (rem_q == '0) begin
          res_status_d = STAT_OK;
        end else begin
          rem_d    = rem_q - REM_BITS'(1);
          key_sh_d = key_sh_q << 1;
          if (child == '0) begin
            next_free_d = next_free_q + NF_BITS'(1);
            cur_l0_d    = '0;
            cur_l1_d    = '0;
            cur_cnt_d   = COUNT_BITS'(1);
            cur_idx_d   = nf_idx;
          end else begin
            cur_idx_d = child;
          end
        end
      end
      ST_ADD_LOAD: begin
        cur_l0_d  = rd_a_l0;
        cur_l1_d  = rd_a_l1;
        cur_cnt_d = rd_a_cnt + COUNT_BITS'(1);
      end
      ST_DCHK_STEP: begin
        if (rem_q == '0) begin
          if (cur_cnt_q == '0) begin
            res_status_d = STAT_ABSENT;
          end else begin
            root_cnt_d = root_cnt_q - COUNT_BITS'(1);
            cur_l0_d   = root_l0_q;
            cur_l1_d   = root_l1_q;
            rem_d      = REM_BITS'(KEY_BITS);
            key_sh_d   = key_q;
          end
        end else if (child == '0) begin
          res_status_d = STAT_ABSENT;
        end else begin
          rem_d    = rem_q - REM_BITS'(1);
          key_sh_d = key_sh_q << 1;
        end
      end
      ST_DCHK_LOAD: begin
        cur_l0_d  = rd_a_l0;
        cur_l1_d  = rd_a_l1;
        cur_cnt_d = rd_a_cnt;
      end
      ST_DUPD_STEP: begin
        if (rem_q == '0) begin
          res_status_d = STAT_OK;
        end else begin
          cur_idx_d = child;
          rem_d     = rem_q - REM_BITS'(1);
          key_sh_d  = key_sh_q << 1;
        end
      end
      ST_DUPD_LOAD: begin
        mem_we   = 1'b1;
        wdata    = {rd_a_l1, rd_a_l0, rd_a_cnt - COUNT_BITS'(1)};
        cur_l0_d = rd_a_l0;
        cur_l1_d = rd_a_l1;
      end
      ST_QRY_STEP: begin
        if (rem_q == '0) begin
          res_status_d = STAT_OK;
          res_ans_d    = ans_q;
        end
      end
      ST_QRY_LOAD: begin
        ans_d    = (ans_q << 1) | KEY_BITS'(take ^ bit_w);
        rem_d    = rem_q - REM_BITS'(1);
        key_sh_d = key_sh_q << 1;
        // a missing link falls back to the root
        if (take_link == '0) begin
          cur_l0_d = root_l0_q;
          cur_l1_d = root_l1_q;
        end else if (take) begin
          cur_l0_d = rd_b_l0;
          cur_l1_d = rd_b_l1;
        end else begin
          cur_l0_d = rd_a_l0;
          cur_l1_d = rd_a_l1;
        end
      end
      ST_RESP: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_ans_d    = res_ans_q;
          out_status_d = res_status_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      root_l0_q   <= '0;
      root_l1_q   <= '0;
      root_cnt_q  <= '0;
      next_free_q <= NF_BITS'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      root_l0_q   <= root_l0_d;
      root_l1_q   <= root_l1_d;
      root_cnt_q  <= root_cnt_d;
      next_free_q <= next_free_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_l0_q     <= cur_l0_d;
    cur_l1_q     <= cur_l1_d;
    cur_cnt_q    <= cur_cnt_d;
    cur_idx_q    <= cur_idx_d;
    key_q        <= key_d;
    key_sh_q     <= key_sh_d;
    ans_q        <= ans_d;
    rem_q        <= rem_d;
    max_q        <= max_d;
    res_status_q <= res_status_d;
    res_ans_q    <= res_ans_d;
    out_ans_q    <= out_ans_d;
    out_status_q <= out_status_d;
  end

endmodule

[rtl/btxq_checker.sv]
`timescale 1ns / 1ps
// port checker of the binary trie xor query unit and its bind
module btxq_checker
  import btxq_pkg::*;
#(
  parameter int KEY_BITS = 30
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                req_valid_i,
  input logic                req_ready_i,
  input logic                rsp_valid_i,
  input logic                rsp_ready_i,
  input logic [KEY_BITS-1:0] rsp_answer_i,
  input logic [1:0]          rsp_status_i
);

  logic [1:0] pending_q, pending_d;
  logic       req_acc, rsp_acc;

  assign req_acc   = req_valid_i && req_ready_i;
  assign rsp_acc   = rsp_valid_i && rsp_ready_i;
  assign pending_d = pending_q + 2'(req_acc) - 2'(rsp_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  // a stalled result item holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      rsp_valid_i && $stable(rsp_answer_i) && $stable(rsp_status_i))
    else $error("result item changed while stalled");

  a_nonok_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i != STAT_OK) |-> rsp_answer_i == '0)
    else $error("non-ok result carries a nonzero answer");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> !req_ready_i)
    else $error("request taken while an item is in work");

  a_no_extra_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> pending_q != 2'd0)
    else $error("result item without a request item");

  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q != 2'd3)
    else $error("more than two items outstanding");

endmodule

bind binary_trie_xor_query_unit btxq_checker #(.KEY_BITS(KEY_BITS)) u_btxq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_answer_i (rsp_o.answer),
  .rsp_status_i (rsp_o.status)
);
